// ----- design/pect_pkg.sv -----
// ----------------------------------------------------------------------------
// pect_pkg
// Shared types and constants for the polygon ear-clip triangulator.
// ----------------------------------------------------------------------------
package pect_pkg;

    localparam int COORD_W  = 24;
    localparam int NORM_W   = 16;
    localparam int EPS_W    = 24;
    localparam int EPS_SH   = 14;
    localparam int CORNER_W = 6;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int TURN_W   = 64;
    localparam int MIN_POLY = 3;
    localparam logic [EPS_W-1:0] EPS_RESET = 24'd16;

    typedef enum logic [5:0] {
        S_LOAD, S_START, S_INIT, S_ROUND,
        S_TR0, S_TR1, S_TR2, S_TR3,
        S_TS0, S_TS1, S_TS2, S_TS3, S_TS4, S_TW,
        S_BINIT, S_BR0, S_BR1, S_BD,
        S_JR0, S_JR1, S_JQ, S_JS, S_JW0, S_JW1, S_JW2, S_JN,
        S_BNEXT, S_OUT, S_SHIFT, S_SH0, S_SH1, S_FINISH
    } state_t;

    typedef enum logic [1:0] {PH_TURN, PH_EAR, PH_EMIT} phase_t;
    typedef enum logic [1:0] {RA_PREV, RA_CUR, RA_NEXT, RA_J} ring_ra_t;
    typedef enum logic [1:0] {SA_P, SA_C, SA_N, SA_Q} store_ra_t;
    typedef enum logic [1:0] {TRI_TURN, TRI_D0, TRI_D1, TRI_D2} tri_sel_t;
    typedef enum logic [2:0] {IOP_HOLD, IOP_CLR, IOP_INC, IOP_ONE, IOP_BEST} idx_op_t;

    typedef struct packed {
        logic      load;
        logic      ring_we;
        logic      ring_init;
        ring_ra_t  ring_ra;
        store_ra_t store_ra;
        logic      turn_ra_j;
        logic      cap_p;
        logic      cap_c;
        logic      cap_a;
        logic      cap_b;
        logic      cap_cpt;
        logic      cap_q;
        logic      tri_start;
        tri_sel_t  tri_sel;
        logic      turn_we;
        idx_op_t   i_op;
        idx_op_t   j_op;
        logic      best_clr;
        logic      best_upd;
        logic      cap_turn;
        logic      sign_first;
        logic      sign_acc;
        logic      m_load;
        logic      m_dec;
        logic      out_load;
        logic      out_short;
        logic      clear_poly;
    } cmd_t;

    typedef struct packed {
        logic cnt_short;
        logic init_done;
        logic m_is3;
        logic i_last;
        logic j_last;
        logic reflex_rd;
        logic skip_j;
        logic turn_gt_e;
        logic tri_done;
        logic hit;
        logic out_last;
    } sts_t;

endpackage

// ----- design/pect_triple.sv -----
// ----------------------------------------------------------------------------
// pect_triple
// Pipelined triple product (u x v) . n, saturated to 64 bits, six stages.
// ----------------------------------------------------------------------------
module pect_triple
    import pect_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] u_in [3],
    input  logic signed [DIFF_W-1:0] v_in [3],
    input  logic signed [NORM_W-1:0] nrm  [3],
    output logic                     done,
    output logic signed [TURN_W-1:0] result
);

    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LO_SPL  = 26;
    localparam int LO_W    = LO_SPL + 1 + NORM_W;
    localparam int HI_W    = CROSS_W - LO_SPL + NORM_W;
    localparam int TERM_W  = CROSS_W + NORM_W + 1;
    localparam int SUM_W   = TERM_W + 2;

    logic [5:0]               valid_reg;
    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  v_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [6];
    logic signed [CROSS_W-1:0] cross_reg [3];
    logic signed [LO_W-1:0]    lo_reg [3];
    logic signed [HI_W-1:0]    hi_reg [3];
    logic signed [TERM_W-1:0]  term_reg [3];
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            u_reg <= u_in;
            v_reg <= v_in;
        end
        prod_reg[0] <= u_reg[1] * v_reg[2];
        prod_reg[1] <= u_reg[2] * v_reg[1];
        prod_reg[2] <= u_reg[2] * v_reg[0];
        prod_reg[3] <= u_reg[0] * v_reg[2];
        prod_reg[4] <= u_reg[0] * v_reg[1];
        prod_reg[5] <= u_reg[1] * v_reg[0];
        for (int k = 0; k < 3; k++)
        begin
            cross_reg[k] <= CROSS_W'(prod_reg[2*k]) - CROSS_W'(prod_reg[2*k+1]);
            lo_reg[k]    <= $signed({1'b0, cross_reg[k][LO_SPL-1:0]}) * nrm[k];
            hi_reg[k]    <= $signed(cross_reg[k][CROSS_W-1:LO_SPL]) * nrm[k];
            term_reg[k]  <= (TERM_W'(hi_reg[k]) <<< LO_SPL) + TERM_W'(lo_reg[k]);
        end
        sum_reg <= SUM_W'(term_reg[0]) + SUM_W'(term_reg[1]) + SUM_W'(term_reg[2]);
    end

    assign fits = (&sum_reg[SUM_W-1:TURN_W-1]) || !(|sum_reg[SUM_W-1:TURN_W-1]);
    assign done = valid_reg[5];

    always_comb
    begin
        if (fits)
            result = sum_reg[TURN_W-1:0];
        else if (sum_reg[SUM_W-1])
            result = {1'b1, {(TURN_W-1){1'b0}}};
        else
            result = {1'b0, {(TURN_W-1){1'b1}}};
    end

endmodule

// ----- design/pect_dp.sv -----
// ----------------------------------------------------------------------------
// pect_dp
// Datapath: vertex, ring and turn memories, index registers, triple unit.
// ----------------------------------------------------------------------------
module pect_dp
    import pect_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      cfg_we,
    input  logic [EPS_W-1:0]          cfg_data,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic signed [NORM_W-1:0]  normal_x,
    input  logic signed [NORM_W-1:0]  normal_y,
    input  logic signed [NORM_W-1:0]  normal_z,
    output logic [CORNER_W-1:0]       corner_a,
    output logic [CORNER_W-1:0]       corner_b,
    output logic [CORNER_W-1:0]       corner_c,
    output logic                      last_triangle,
    output logic                      empty_res,
    output logic                      overflow
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = 3 * COORD_W;

    function automatic logic [CORNER_W-1:0] to_corner(input logic [IW-1:0] idx);
        logic [IW+CORNER_W-1:0] wide;
        wide = {{CORNER_W{1'b0}}, idx};
        return wide[CORNER_W-1:0];
    endfunction

    // control registers
    logic [CW-1:0]            cnt_reg, m_reg;
    logic                     dropped_reg;
    logic signed [NORM_W-1:0] nrm_reg [3];
    logic [EPS_W-1:0]         eps_reg;

    // payload registers
    logic [IW-1:0]             i_reg, j_reg, best_reg, p_reg, c_reg;
    logic signed [TURN_W-1:0]  best_turn_reg, turn_i_reg;
    logic signed [COORD_W-1:0] pt_reg [4][3];
    logic                      neg_reg, pos_reg;
    logic [CORNER_W-1:0]       ca_reg, cb_reg, cc_reg;
    logic                      last_reg, empty_reg, ovf_reg;

    // memories
    logic [SW-1:0]     store_mem [MAX_VERTICES];
    logic [IW-1:0]     ring_mem  [MAX_VERTICES];
    logic [TURN_W:0]   turn_mem  [MAX_VERTICES];
    logic [SW-1:0]     store_rd_reg;
    logic [IW-1:0]     ring_rd_reg;
    logic [TURN_W:0]   turn_rd_reg;

    logic [IW-1:0]             prev_pos, next_pos, ring_ra, store_ra, turn_ra;
    logic                      i_last, cnt_room;
    logic signed [TURN_W-1:0]  e64, tri_res, turn_rd_val;
    logic                      tri_done, res_neg, res_pos;
    logic signed [DIFF_W-1:0]  u_in [3];
    logic signed [DIFF_W-1:0]  v_in [3];
    logic [1:0]                s0, s1, s2, s3;

    assign cnt_room    = cnt_reg < CW'(MAX_VERTICES);
    assign i_last      = CW'(i_reg) == m_reg - 1'b1;
    assign prev_pos    = (i_reg == '0) ? IW'(m_reg - 1'b1) : i_reg - 1'b1;
    assign next_pos    = i_last ? '0 : i_reg + 1'b1;
    assign e64         = TURN_W'({eps_reg, {EPS_SH{1'b0}}});
    assign turn_rd_val = turn_rd_reg[TURN_W-1:0];
    assign res_neg     = tri_res < 0;
    assign res_pos     = tri_res > 0;

    always_comb
    begin
        unique case (cmd.ring_ra)
            RA_PREV: ring_ra = prev_pos;
            RA_CUR:  ring_ra = i_reg;
            RA_NEXT: ring_ra = next_pos;
            RA_J:    ring_ra = j_reg;
            default: ring_ra = i_reg;
        endcase
        unique case (cmd.store_ra)
            SA_P:    store_ra = p_reg;
            SA_C:    store_ra = c_reg;
            SA_N:    store_ra = ring_rd_reg;
            SA_Q:    store_ra = ring_rd_reg;
            default: store_ra = p_reg;
        endcase
        turn_ra = cmd.turn_ra_j ? j_reg : i_reg;
    end

    // n is read back from the ring register; keep a copy for the ear tests
    logic [IW-1:0] n_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && cnt_room)
            store_mem[cnt_reg[IW-1:0]] <= {coord_x, coord_y, coord_z};
        store_rd_reg <= store_mem[store_ra];
        if (cmd.ring_we)
            ring_mem[i_reg] <= cmd.ring_init ? i_reg : ring_rd_reg;
        ring_rd_reg <= ring_mem[ring_ra];
        if (cmd.turn_we)
            turn_mem[i_reg] <= {tri_res < -e64, tri_res};
        turn_rd_reg <= turn_mem[turn_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            m_reg       <= '0;
            dropped_reg <= 1'b0;
            nrm_reg     <= '{default: '0};
            eps_reg     <= EPS_RESET;
        end
        else
        begin
            if (cfg_we)
                eps_reg <= cfg_data;
            if (cmd.load)
            begin
                if (cnt_reg == '0)
                    nrm_reg <= '{normal_x, normal_y, normal_z};
                if (cnt_room)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.clear_poly)
            begin
                cnt_reg     <= '0;
                dropped_reg <= 1'b0;
                nrm_reg     <= '{default: '0};
            end
            if (cmd.m_load)
                m_reg <= cnt_reg;
            else if (cmd.m_dec)
                m_reg <= m_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.i_op)
            IOP_HOLD: i_reg <= i_reg;
            IOP_CLR:  i_reg <= '0;
            IOP_INC:  i_reg <= i_reg + 1'b1;
            IOP_ONE:  i_reg <= IW'(1);
            IOP_BEST: i_reg <= best_reg;
            default:  i_reg <= i_reg;
        endcase
        unique case (cmd.j_op)
            IOP_CLR: j_reg <= '0;
            IOP_INC: j_reg <= j_reg + 1'b1;
            default: j_reg <= j_reg;
        endcase
        if (cmd.best_clr)
        begin
            best_reg      <= '0;
            best_turn_reg <= {1'b1, {(TURN_W-1){1'b0}}};
        end
        else if (cmd.best_upd && turn_rd_val > best_turn_reg)
        begin
            best_reg      <= i_reg;
            best_turn_reg <= turn_rd_val;
        end
        if (cmd.cap_turn)
            turn_i_reg <= turn_rd_val;
        if (cmd.cap_p)
            p_reg <= ring_rd_reg;
        if (cmd.cap_c)
            c_reg <= ring_rd_reg;
        if (cmd.cap_a)
            n_reg <= ring_rd_reg;
        if (cmd.cap_a)
            pt_reg[0] <= '{store_rd_reg[SW-1 -: COORD_W], store_rd_reg[2*COORD_W-1 -: COORD_W],
                           store_rd_reg[COORD_W-1:0]};
        if (cmd.cap_b)
            pt_reg[1] <= '{store_rd_reg[SW-1 -: COORD_W], store_rd_reg[2*COORD_W-1 -: COORD_W],
                           store_rd_reg[COORD_W-1:0]};
        if (cmd.cap_cpt)
            pt_reg[2] <= '{store_rd_reg[SW-1 -: COORD_W], store_rd_reg[2*COORD_W-1 -: COORD_W],
                           store_rd_reg[COORD_W-1:0]};
        if (cmd.cap_q)
            pt_reg[3] <= '{store_rd_reg[SW-1 -: COORD_W], store_rd_reg[2*COORD_W-1 -: COORD_W],
                           store_rd_reg[COORD_W-1:0]};
        if (cmd.sign_first)
        begin
            neg_reg <= res_neg;
            pos_reg <= res_pos;
        end
        else if (cmd.sign_acc)
        begin
            neg_reg <= neg_reg | res_neg;
            pos_reg <= pos_reg | res_pos;
        end
        if (cmd.out_load)
        begin
            ca_reg    <= cmd.out_short ? '0 : to_corner(p_reg);
            cb_reg    <= cmd.out_short ? '0 : to_corner(c_reg);
            cc_reg    <= cmd.out_short ? '0 : to_corner(ring_rd_reg);
            last_reg  <= cmd.out_short | (m_reg == CW'(MIN_POLY));
            empty_reg <= cmd.out_short;
            ovf_reg   <= dropped_reg;
        end
    end

    // operand routing: u = s1 - s0, v = s2 - s3 (A=0, B=1, C=2, Q=3)
    always_comb
    begin
        unique case (cmd.tri_sel)
            TRI_TURN: begin s0 = 2'd0; s1 = 2'd1; s2 = 2'd2; s3 = 2'd1; end
            TRI_D0:   begin s0 = 2'd0; s1 = 2'd1; s2 = 2'd3; s3 = 2'd0; end
            TRI_D1:   begin s0 = 2'd1; s1 = 2'd2; s2 = 2'd3; s3 = 2'd1; end
            TRI_D2:   begin s0 = 2'd2; s1 = 2'd0; s2 = 2'd3; s3 = 2'd2; end
            default:  begin s0 = 2'd0; s1 = 2'd1; s2 = 2'd2; s3 = 2'd1; end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            u_in[k] = DIFF_W'(pt_reg[s1][k]) - DIFF_W'(pt_reg[s0][k]);
            v_in[k] = DIFF_W'(pt_reg[s2][k]) - DIFF_W'(pt_reg[s3][k]);
        end
    end

    pect_triple u_triple (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.tri_start),
        .u_in   (u_in),
        .v_in   (v_in),
        .nrm    (nrm_reg),
        .done   (tri_done),
        .result (tri_res)
    );

    always_comb
    begin
        sts.cnt_short = cnt_reg < CW'(MIN_POLY);
        sts.init_done = CW'(i_reg) == cnt_reg - 1'b1;
        sts.m_is3     = m_reg == CW'(MIN_POLY);
        sts.i_last    = i_last;
        sts.j_last    = CW'(j_reg) == m_reg - 1'b1;
        sts.reflex_rd = turn_rd_reg[TURN_W];
        sts.skip_j    = !turn_rd_reg[TURN_W] || ring_rd_reg == p_reg ||
                        ring_rd_reg == c_reg || ring_rd_reg == n_reg;
        sts.turn_gt_e = turn_i_reg > e64;
        sts.tri_done  = tri_done;
        sts.hit       = !((neg_reg | res_neg) && (pos_reg | res_pos));
        sts.out_last  = last_reg;
    end

    assign corner_a      = ca_reg;
    assign corner_b      = cb_reg;
    assign corner_c      = cc_reg;
    assign last_triangle = last_reg;
    assign empty_res     = empty_reg;
    assign overflow      = ovf_reg;

endmodule

// ----- design/pect_ctrl.sv -----
// ----------------------------------------------------------------------------
// pect_ctrl
// Sequencer: load, ring setup, turn pass, ear search, emit and ring removal.
// ----------------------------------------------------------------------------
module pect_ctrl
    import pect_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_vertex,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_ready,
    output logic out_valid
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= PH_TURN;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_LOAD:   if (in_valid && last_vertex) state_next = S_START;
            S_START:  state_next = sts.cnt_short ? S_OUT : S_INIT;
            S_INIT:   if (sts.init_done) state_next = S_ROUND;
            S_ROUND:
            begin
                state_next = S_TR0;
                phase_next = sts.m_is3 ? PH_EMIT : PH_TURN;
            end
            S_TR0:    state_next = S_TR1;
            S_TR1:    state_next = S_TR2;
            S_TR2:    state_next = S_TR3;
            S_TR3:    state_next = (phase_reg == PH_EMIT) ? S_OUT : S_TS0;
            S_TS0:    state_next = S_TS1;
            S_TS1:    state_next = S_TS2;
            S_TS2:    state_next = S_TS3;
            S_TS3:    state_next = (phase_reg == PH_TURN) ? S_TS4 : S_BD;
            S_TS4:    state_next = S_TW;
            S_TW:     if (sts.tri_done) state_next = sts.i_last ? S_BINIT : S_TR0;
            S_BINIT:  state_next = S_BR0;
            S_BR0:    state_next = S_BR1;
            S_BR1:
            begin
                if (sts.reflex_rd)
                    state_next = S_BNEXT;
                else
                begin
                    state_next = S_TR0;
                    phase_next = PH_EAR;
                end
            end
            S_BD:
            begin
                if (sts.turn_gt_e)
                    state_next = S_JR0;
                else
                begin
                    state_next = S_TR0;
                    phase_next = PH_EMIT;
                end
            end
            S_JR0:    state_next = S_JR1;
            S_JR1:    state_next = sts.skip_j ? S_JN : S_JQ;
            S_JQ:     state_next = S_JS;
            S_JS:     state_next = S_JW0;
            S_JW0:    if (sts.tri_done) state_next = S_JW1;
            S_JW1:    if (sts.tri_done) state_next = S_JW2;
            S_JW2:    if (sts.tri_done) state_next = sts.hit ? S_BNEXT : S_JN;
            S_JN:
            begin
                if (sts.j_last)
                begin
                    state_next = S_TR0;
                    phase_next = PH_EMIT;
                end
                else
                    state_next = S_JR0;
            end
            S_BNEXT:
            begin
                if (sts.i_last)
                begin
                    state_next = S_TR0;
                    phase_next = PH_EMIT;
                end
                else
                    state_next = S_BR0;
            end
            S_OUT:    if (out_ready) state_next = sts.out_last ? S_FINISH : S_SHIFT;
            S_SHIFT:  state_next = sts.i_last ? S_ROUND : S_SH0;
            S_SH0:    state_next = S_SH1;
            S_SH1:    state_next = S_SHIFT;
            S_FINISH: state_next = S_LOAD;
            default:  state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_START:
            begin
                if (sts.cnt_short)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_short = 1'b1;
                end
                else
                    cmd.i_op = IOP_CLR;
            end
            S_INIT:
            begin
                cmd.ring_we   = 1'b1;
                cmd.ring_init = 1'b1;
                if (sts.init_done)
                    cmd.m_load = 1'b1;
                else
                    cmd.i_op = IOP_INC;
            end
            S_ROUND:  cmd.i_op = sts.m_is3 ? IOP_ONE : IOP_CLR;
            S_TR0:    cmd.ring_ra = RA_PREV;
            S_TR1:
            begin
                cmd.ring_ra = RA_CUR;
                cmd.cap_p   = 1'b1;
            end
            S_TR2:
            begin
                cmd.ring_ra = RA_NEXT;
                cmd.cap_c   = 1'b1;
            end
            S_TR3:
            begin
                cmd.ring_ra  = RA_NEXT;
                cmd.out_load = (phase_reg == PH_EMIT);
            end
            S_TS0:
            begin
                cmd.ring_ra  = RA_NEXT;
                cmd.store_ra = SA_P;
            end
            S_TS1:
            begin
                cmd.ring_ra  = RA_NEXT;
                cmd.store_ra = SA_C;
                cmd.cap_a    = 1'b1;
            end
            S_TS2:
            begin
                cmd.store_ra = SA_N;
                cmd.cap_b    = 1'b1;
            end
            S_TS3:    cmd.cap_cpt = 1'b1;
            S_TS4:
            begin
                cmd.tri_start = 1'b1;
                cmd.tri_sel   = TRI_TURN;
            end
            S_TW:
            begin
                if (sts.tri_done)
                begin
                    cmd.turn_we = 1'b1;
                    if (!sts.i_last)
                        cmd.i_op = IOP_INC;
                end
            end
            S_BINIT:
            begin
                cmd.i_op     = IOP_CLR;
                cmd.best_clr = 1'b1;
            end
            S_BR0:    cmd.turn_ra_j = 1'b0;
            S_BR1:
            begin
                cmd.best_upd = 1'b1;
                cmd.cap_turn = 1'b1;
            end
            S_BD:     if (sts.turn_gt_e) cmd.j_op = IOP_CLR;
            S_JR0:
            begin
                cmd.ring_ra   = RA_J;
                cmd.turn_ra_j = 1'b1;
            end
            S_JR1:    cmd.store_ra = SA_Q;
            S_JQ:     cmd.cap_q = 1'b1;
            S_JS:
            begin
                cmd.tri_start = 1'b1;
                cmd.tri_sel   = TRI_D0;
            end
            S_JW0:
            begin
                cmd.tri_sel = TRI_D1;
                if (sts.tri_done)
                begin
                    cmd.sign_first = 1'b1;
                    cmd.tri_start  = 1'b1;
                end
            end
            S_JW1:
            begin
                cmd.tri_sel = TRI_D2;
                if (sts.tri_done)
                begin
                    cmd.sign_acc  = 1'b1;
                    cmd.tri_start = 1'b1;
                end
            end
            S_JW2:    cmd.tri_sel = TRI_D2;
            S_JN:     if (!sts.j_last) cmd.j_op = IOP_INC;
            S_BNEXT:  cmd.i_op = sts.i_last ? IOP_BEST : IOP_INC;
            S_OUT:    out_valid = 1'b1;
            S_SHIFT:  cmd.m_dec = sts.i_last;
            S_SH0:    cmd.ring_ra = RA_NEXT;
            S_SH1:
            begin
                cmd.ring_we = 1'b1;
                cmd.i_op    = IOP_INC;
            end
            S_FINISH: cmd.clear_poly = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

// ----- design/polygon_ear_clip_triangulator.sv -----
// ----------------------------------------------------------------------------
// polygon_ear_clip_triangulator
// Loads one polygon and ear-clips it into index triples, one per request.
//
//  channel   signals                              moves
//  in        in_valid / in_ready                  one vertex request
//  out       out_valid / out_ready                one triangle request
//  cfg       cfg_valid / cfg_ready (always high)  epsilon write
//
//  Loading accepts one vertex per cycle. With m live vertices (m > 3) a
//  round first computes a turn value for every vertex, then per ear
//  candidate runs up to m containment checks (three passes of the 6-stage
//  triple-product unit each), then shifts the ring to close it.
//  Reset is asynchronous, active low; memories need no clearing.
//  No vertex is taken while a polygon is being clipped; a stalled output
//  holds the sequencer.
// ----------------------------------------------------------------------------
module polygon_ear_clip_triangulator
    import pect_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [EPS_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic signed [NORM_W-1:0]  normal_x,
    input  logic signed [NORM_W-1:0]  normal_y,
    input  logic signed [NORM_W-1:0]  normal_z,
    input  logic                      last_vertex,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CORNER_W-1:0]       corner_a,
    output logic [CORNER_W-1:0]       corner_b,
    output logic [CORNER_W-1:0]       corner_c,
    output logic                      last_triangle,
    output logic                      empty_res,
    output logic                      overflow
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pect_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_vertex (last_vertex),
        .out_ready   (out_ready),
        .sts         (sts),
        .cmd         (cmd),
        .in_ready    (in_ready),
        .out_valid   (out_valid)
    );

    pect_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .corner_a      (corner_a),
        .corner_b      (corner_b),
        .corner_c      (corner_c),
        .last_triangle (last_triangle),
        .empty_res     (empty_res),
        .overflow      (overflow)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("vertex taken while a triangle is pending");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last_triangle && corner_a == '0 && corner_c == '0)
        else $error("empty result malformed");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_triangle |=> !out_valid)
        else $error("result after final triangle");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polygon_ear_clip_triangulator. Polygons are streamed
// in as vertex requests, an in-bench ear-clipping predictor builds the expected
// triangle requests, and every output request is compared against them.
// ----------------------------------------------------------------------------
module tb;
    import pect_pkg::*;

    typedef struct {
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
        logic                last;
        logic                empty;
        logic                ovf;
    } tri_t;

    localparam int NV = 64;
    localparam int STALL_LIMIT = 600000;

    class tri_scoreboard;
        logic signed [COORD_W-1:0] px[NV], py[NV], pz[NV];
        logic signed [NORM_W-1:0]  nrm[3];
        int                        count;
        bit                        dropped;
        logic [EPS_W-1:0]          eps = EPS_RESET;
        tri_t                      expected[$];
        int                        errors;

        function void vec(int f, int t, output longint d[3]);
            d[0] = longint'(px[t]) - longint'(px[f]);
            d[1] = longint'(py[t]) - longint'(py[f]);
            d[2] = longint'(pz[t]) - longint'(pz[f]);
        endfunction

        function longint triple3(longint u[3], longint v[3]);
            logic signed [127:0] w0, w1, w2, n0, n1, n2, s;
            longint cx, cy, cz;
            cx = u[1] * v[2] - u[2] * v[1];
            cy = u[2] * v[0] - u[0] * v[2];
            cz = u[0] * v[1] - u[1] * v[0];
            w0 = cx; w1 = cy; w2 = cz;
            n0 = nrm[0]; n1 = nrm[1]; n2 = nrm[2];
            s = w0 * n0 + w1 * n1 + w2 * n2;
            if (s > 128'sh7fff_ffff_ffff_ffff)
                return 64'sh7fff_ffff_ffff_ffff;
            if (s < -128'sh8000_0000_0000_0000)
                return 64'sh8000_0000_0000_0000;
            return longint'(s);
        endfunction

        function longint turn(int p, int c, int n);
            longint u[3], v[3];
            vec(p, c, u);
            vec(c, n, v);
            return triple3(u, v);
        endfunction

        function bit in_tri(int a, int b, int c, int q);
            longint u[3], v[3], d0, d1, d2;
            bit neg, pos;
            vec(a, b, u); vec(a, q, v); d0 = triple3(u, v);
            vec(b, c, u); vec(b, q, v); d1 = triple3(u, v);
            vec(c, a, u); vec(c, q, v); d2 = triple3(u, v);
            neg = d0 < 0 || d1 < 0 || d2 < 0;
            pos = d0 > 0 || d1 > 0 || d2 > 0;
            return !(neg && pos);
        endfunction

        function void push(int a, int b, int c, bit last, bit empty);
            tri_t t;
            t.a = a[5:0]; t.b = b[5:0]; t.c = c[5:0];
            t.last = last; t.empty = empty; t.ovf = dropped;
            expected = {expected, t};
        endfunction

        function void clip_polygon();
            int     ring[NV];
            longint tv[NV];
            bit     rf[NV];
            int     m, at, best, p, c, n, q, i, j;
            bit     hit;
            longint e;
            m = count;
            e = longint'({40'd0, eps}) << EPS_SH;
            if (m < MIN_POLY) begin
                push(0, 0, 0, 1, 1);
                return;
            end
            for (i = 0; i < m; i++)
                ring[i] = i;
            while (m > 3) begin
                at = m;
                best = 0;
                for (i = 0; i < m; i++) begin
                    tv[i] = turn(ring[(i + m - 1) % m], ring[i], ring[(i + 1) % m]);
                    rf[i] = tv[i] < -e;
                end
                for (i = 0; i < m && at == m; i++) begin
                    hit = 0;
                    if (tv[i] > tv[best])
                        best = i;
                    if (!rf[i]) begin
                        p = ring[(i + m - 1) % m];
                        c = ring[i];
                        n = ring[(i + 1) % m];
                        if (tv[i] > e) begin
                            for (j = 0; j < m && !hit; j++) begin
                                q = ring[j];
                                if (rf[j] && q != p && q != c && q != n)
                                    hit = in_tri(p, c, n, q);
                            end
                        end
                        if (!hit)
                            at = i;
                    end
                end
                if (at == m)
                    at = best;
                push(ring[(at + m - 1) % m], ring[at], ring[(at + 1) % m], 0, 0);
                for (i = at; i < m - 1; i++)
                    ring[i] = ring[i + 1];
                m--;
            end
            push(ring[0], ring[1], ring[2], 1, 0);
        endfunction

        function void note_vertex(logic signed [COORD_W-1:0] x, y, z,
                                  logic signed [NORM_W-1:0] nx, ny, nz, bit last);
            if (count == 0) begin
                nrm[0] = nx; nrm[1] = ny; nrm[2] = nz;
            end
            if (count < NV) begin
                px[count] = x; py[count] = y; pz[count] = z;
                count++;
            end else
                dropped = 1;
            if (last) begin
                clip_polygon();
                count = 0;
                dropped = 0;
                nrm[0] = '0; nrm[1] = '0; nrm[2] = '0;
            end
        endfunction

        function void check_result(tri_t got);
            tri_t w;
            if (expected.size() == 0) begin
                $error("unexpected triangle request %0d %0d %0d", got.a, got.b, got.c);
                errors++;
                return;
            end
            w = expected.pop_front();
            if (got.a !== w.a) begin
                $error("corner_a exp %0d got %0d", w.a, got.a); errors++;
            end
            if (got.b !== w.b) begin
                $error("corner_b exp %0d got %0d", w.b, got.b); errors++;
            end
            if (got.c !== w.c) begin
                $error("corner_c exp %0d got %0d", w.c, got.c); errors++;
            end
            if (got.last !== w.last) begin
                $error("last_triangle exp %0d got %0d", w.last, got.last); errors++;
            end
            if (got.empty !== w.empty) begin
                $error("empty_res exp %0d got %0d", w.empty, got.empty); errors++;
            end
            if (got.ovf !== w.ovf) begin
                $error("overflow exp %0d got %0d", w.ovf, got.ovf); errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [EPS_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
    logic signed [NORM_W-1:0]  normal_x, normal_y, normal_z;
    logic                      last_vertex;
    logic                      out_valid;
    logic                      out_ready;
    logic [CORNER_W-1:0]       corner_a, corner_b, corner_c;
    logic                      last_triangle, empty_res, overflow;

    tri_scoreboard sb = new();
    int            idle_in;
    int            idle_out;
    int            stall_cnt;
    int            sent;

    polygon_ear_clip_triangulator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .last_vertex(last_vertex),
        .out_valid(out_valid), .out_ready(out_ready),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .last_triangle(last_triangle), .empty_res(empty_res), .overflow(overflow)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // output side: check, stall at random, watchdog
    initial
    begin
        tri_t got;
        out_ready = 0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.a = corner_a; got.b = corner_b; got.c = corner_c;
                got.last = last_triangle; got.empty = empty_res; got.ovf = overflow;
                sb.check_result(got);
            end
            if ((out_valid && out_ready) || (in_valid && in_ready) ||
                (cfg_valid && cfg_ready))
                stall_cnt = 0;
            else if (rst_n)
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
            out_ready <= ($urandom_range(99) >= idle_out);
        end
    end

    task automatic send_vertex(logic signed [COORD_W-1:0] x, y, z,
                               logic signed [NORM_W-1:0] nx, ny, nz, bit last);
        while ($urandom_range(99) < idle_in) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid    <= 1;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        normal_x    <= nx;
        normal_y    <= ny;
        normal_z    <= nz;
        last_vertex <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_vertex(x, y, z, nx, ny, nz, last);
        sent++;
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        in_valid <= 0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.eps = v;
        cfg_valid <= 0;
    endtask

    // sends an n-vertex polygon; shape: 0 convex, 1 star, 2 small random, 3 full range
    task automatic send_polygon(int n, int shape);
        logic signed [NORM_W-1:0] nx, ny, nz;
        real ang, r;
        int  k, sel;
        logic signed [COORD_W-1:0] x, y, z;
        sel = $urandom_range(9);
        if (sel < 5) begin
            nx = 0; ny = 0; nz = 16384;
        end else if (sel < 7) begin
            nx = 0; ny = 0; nz = -16384;
        end else if (sel < 9) begin
            nx = NORM_W'($urandom_range(32768) - 16384);
            ny = NORM_W'($urandom_range(32768) - 16384);
            nz = NORM_W'($urandom_range(32768) - 16384);
        end else begin
            nx = NORM_W'($urandom); ny = NORM_W'($urandom); nz = NORM_W'($urandom);
        end
        for (k = 0; k < n; k++)
        begin
            ang = 6.2831853 * k / n;
            r = (shape == 1 && k % 2) ? 40000.0 : 200000.0;
            case (shape)
                0, 1: begin
                    x = COORD_W'($rtoi(r * $cos(ang)) + $urandom_range(64) - 32);
                    y = COORD_W'($rtoi(r * $sin(ang)) + $urandom_range(64) - 32);
                    z = COORD_W'($urandom_range(3) == 0 ? $urandom_range(200) - 100 : 0);
                end
                2: begin
                    x = COORD_W'($urandom_range(4000) - 2000);
                    y = COORD_W'($urandom_range(4000) - 2000);
                    z = COORD_W'($urandom_range(4000) - 2000);
                end
                default: begin
                    x = COORD_W'($urandom); y = COORD_W'($urandom); z = COORD_W'($urandom);
                end
            endcase
            if (k == 0)
                send_vertex(x, y, z, nx, ny, nz, n == 1);
            else
                send_vertex(x, y, z, NORM_W'($urandom), NORM_W'($urandom),
                            NORM_W'($urandom), k == n - 1);
        end
    endtask

    task automatic random_phase(int goal);
        int start, n;
        start = sent;
        while (sent - start < goal)
        begin
            n = $urandom_range(9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 9);
            send_polygon(n, $urandom_range(3));
        end
        in_valid <= 0;
    endtask

    initial
    begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        in_valid = 0;
        coord_x = 0; coord_y = 0; coord_z = 0;
        normal_x = 0; normal_y = 0; normal_z = 0;
        last_vertex = 0;
        sent = 0;
        idle_in = 13;
        idle_out = 82;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // triangle at coordinate extremes
        send_vertex(24'sh7fffff, 24'sh800000, 24'sh7fffff, 16384, -16384, 16384, 0);
        send_vertex(24'sh800000, 24'sh7fffff, 24'sh800000, 0, 0, 0, 0);
        send_vertex(0, 0, 24'sh7fffff, 0, 0, 0, 1);
        // short polygons
        send_vertex(5, 6, 7, 0, 0, 16384, 1);
        send_vertex(1, 2, 3, -16'sd32768, 16'sh7fff, -16'sd1, 0);
        send_vertex(4, 5, 6, 0, 0, 0, 1);
        // near-collinear vertex
        send_vertex(0, 0, 0, 0, 0, 16384, 0);
        send_vertex(4096, 0, 0, 0, 0, 0, 0);
        send_vertex(8192, 1, 0, 0, 0, 0, 0);
        send_vertex(8192, 8192, 0, 0, 0, 0, 1);
        // concave arrow: reflex vertex inside a candidate ear
        send_vertex(0, 0, 0, 0, 0, 16384, 0);
        send_vertex(40960, 0, 0, 0, 0, 0, 0);
        send_vertex(8192, 8192, 0, 0, 0, 0, 0);
        send_vertex(40960, 40960, 0, 0, 0, 0, 0);
        send_vertex(0, 40960, 0, 0, 0, 0, 1);
        // clockwise square: no ear, most convex wins
        send_vertex(0, 0, 0, 0, 0, 16384, 0);
        send_vertex(0, 40960, 0, 0, 0, 0, 0);
        send_vertex(40960, 40960, 0, 0, 0, 0, 0);
        send_vertex(40960, 0, 0, 0, 0, 0, 1);
        // coincident points, all turns zero
        send_vertex(100, 100, 100, 0, 16384, 0, 0);
        send_vertex(100, 100, 100, 0, 0, 0, 0);
        send_vertex(100, 100, 100, 0, 0, 0, 0);
        send_vertex(100, 100, 100, 0, 0, 0, 1);
        in_valid <= 0;

        write_epsilon(0);
        random_phase(7);

        idle_in = 82;
        idle_out = 13;
        write_epsilon(24'hffffff);
        random_phase(7);

        idle_in = 0;
        idle_out = 0;
        write_epsilon(EPS_W'($urandom_range(4096)));
        random_phase(7);
        send_polygon(66, 0);
        in_valid <= 0;

        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
